// ----- hdl/iqmp_pkg.sv -----
// Package for the I/Q to magnitude/phase converter: beat types, stage type,
// fixed-point widths and the CORDIC arctangent table. No dependencies.
package iqmp_pkg;

   // Sample and datapath widths
   localparam int SAMPLE_BITS  = 16;
   localparam int GUARD_BITS   = 60 - SAMPLE_BITS;
   localparam int CORDIC_W     = 64;
   localparam int ANGLE_W      = 32;
   localparam int ATAN_ENTRIES = 24;
   localparam int SQRT_STEPS   = SAMPLE_BITS;
   localparam int RAD_W        = 2 * SAMPLE_BITS;
   localparam int ROOT_W       = SAMPLE_BITS;
   localparam int REM_W        = SAMPLE_BITS + 2;
   localparam int AMP_W        = 16;
   localparam int PHASE_W      = 16;

   // Accumulator start for a vector turned by pi
   localparam logic [ANGLE_W-1:0] ANGLE_PI   = 32'h8000_0000;
   // Half an output LSB, for rounding the accumulator
   localparam logic [ANGLE_W-1:0] ANGLE_HALF = 32'h0000_8000;

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic [ANGLE_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] i_sample;
      logic signed [SAMPLE_BITS-1:0] q_sample;
      logic                          pulse_end;
   } iqmp_req_type;

   typedef struct packed {
      logic [AMP_W-1:0]          amplitude;
      logic signed [PHASE_W-1:0] phase_angle;
      logic                      pulse_end_out;
   } iqmp_rsp_type;

   // What one cell hands to the next
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [ANGLE_W-1:0]         z;
      logic [RAD_W-1:0]           rad;
      logic [ROOT_W-1:0]          root;
      logic [REM_W-1:0]           rem;
      logic                       zero;
      logic                       pulse_end;
   } iqmp_stage_type;

endpackage

// ----- hdl/iq_to_magnitude_phase.sv -----
// I/Q sample pairs in, rounded magnitude and binary-angle phase out, one beat per
// clock through a fully pipelined chain of cells; throughput is one beat per cycle
// while the output is not stalled. Each beat passes one input stage, one cell per
// CORDIC micro-rotation or square-root digit (whichever count is larger), and the
// rounding/output register. req_ready is registered and drops only while a second
// finished beat sits in the skid register behind a stalled output. Magnitude is
// round(sqrt(I^2+Q^2)); phase is atan2(Q,I) with 32768 = pi, zero vector gives 0.
// Depends on iqmp_pkg, iqmp_front, iqmp_cell and iqmp_out.
module iq_to_magnitude_phase import iqmp_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  iqmp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output iqmp_rsp_type rsp_data
);

   localparam int NCELL = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   logic           pipe_enable;
   logic           stage_valid [NCELL+1];
   iqmp_stage_type stage_data  [NCELL+1];

   assign req_ready = pipe_enable;

   // Input stage
   iqmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   // Chain of cells
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      iqmp_cell #(
         .STEP   (k),
         .ROTATE (k < CORDIC_STAGES),
         .ROOT   (k < SQRT_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // Rounding and output registers
   iqmp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .last_valid  (stage_valid[NCELL]),
      .last_data   (stage_data[NCELL]),
      .pipe_enable (pipe_enable),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hdl/iqmp_front.sv -----
// Input stage: squares for the root, half-plane fold and scaling for the CORDIC.
// Depends on iqmp_pkg.
module iqmp_front import iqmp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  iqmp_req_type   in_data,
   output logic           out_valid,
   output iqmp_stage_type out_data
);

   localparam int EXT_BITS = CORDIC_W - SAMPLE_BITS - GUARD_BITS;

   logic                          valid_ff;
   iqmp_stage_type                data_ff;
   iqmp_stage_type                data_in;
   logic signed [RAD_W-1:0]       i_sq;
   logic signed [RAD_W-1:0]       q_sq;
   logic signed [CORDIC_W-1:0]    x_raw;
   logic signed [CORDIC_W-1:0]    y_raw;

   // Square both samples, scale into the guard-bit format, fold the left half plane
   always_comb begin
      i_sq  = RAD_W'(in_data.i_sample) * RAD_W'(in_data.i_sample);
      q_sq  = RAD_W'(in_data.q_sample) * RAD_W'(in_data.q_sample);
      x_raw = {{EXT_BITS{in_data.i_sample[SAMPLE_BITS-1]}}, in_data.i_sample,
               {GUARD_BITS{1'b0}}};
      y_raw = {{EXT_BITS{in_data.q_sample[SAMPLE_BITS-1]}}, in_data.q_sample,
               {GUARD_BITS{1'b0}}};
      data_in.rad       = RAD_W'($unsigned(i_sq)) + RAD_W'($unsigned(q_sq));
      data_in.root      = '0;
      data_in.rem       = '0;
      data_in.zero      = (in_data.i_sample == '0) && (in_data.q_sample == '0);
      data_in.pulse_end = in_data.pulse_end;
      if (in_data.i_sample[SAMPLE_BITS-1]) begin
         data_in.x = -x_raw;
         data_in.y = -y_raw;
         data_in.z = ANGLE_PI;
      end else begin
         data_in.x = x_raw;
         data_in.y = y_raw;
         data_in.z = '0;
      end
   end

   // Advance when the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/iqmp_cell.sv -----
// One cell of the chain: a CORDIC micro-rotation and/or one square-root digit, as ROTATE and ROOT select.
// Depends on iqmp_pkg.
module iqmp_cell import iqmp_pkg::*; #(
   parameter int STEP   = 0,
   parameter bit ROTATE = 1'b1,
   parameter bit ROOT   = 1'b1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  iqmp_stage_type in_data,
   output logic           out_valid,
   output iqmp_stage_type out_data
);

   localparam logic [ANGLE_W-1:0] ANGLE_STEP = ATAN_TABLE[STEP];

   logic                       valid_ff;
   iqmp_stage_type             data_ff;
   iqmp_stage_type             data_in;
   logic signed [CORDIC_W-1:0] x_sh;
   logic signed [CORDIC_W-1:0] y_sh;
   logic [REM_W-1:0]           rem_trial;
   logic [REM_W-1:0]           sub_val;
   logic                       fits;

   always_comb begin
      data_in   = in_data;
      // Micro-rotation toward the x axis; arithmetic shift floors
      x_sh      = in_data.x >>> STEP;
      y_sh      = in_data.y >>> STEP;
      // Bring down two radicand bits and try the next root digit
      rem_trial = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
      sub_val   = {in_data.root, 2'b01};
      fits      = rem_trial >= sub_val;
      if (ROTATE) begin
         if (!in_data.y[CORDIC_W-1]) begin
            data_in.x = in_data.x + y_sh;
            data_in.y = in_data.y - x_sh;
            data_in.z = in_data.z + ANGLE_STEP;
         end else begin
            data_in.x = in_data.x - y_sh;
            data_in.y = in_data.y + x_sh;
            data_in.z = in_data.z - ANGLE_STEP;
         end
      end
      if (ROOT) begin
         data_in.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
         data_in.rem  = fits ? (rem_trial - sub_val) : rem_trial;
         data_in.root = {in_data.root[ROOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/iqmp_out.sv -----
// Output stage: rounds magnitude and phase, holds the result beat and a skid beat.
// Depends on iqmp_pkg.
module iqmp_out import iqmp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           last_valid,
   input  iqmp_stage_type last_data,
   output logic           pipe_enable,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output iqmp_rsp_type   rsp_data
);

   logic               out_valid_ff;
   logic               out_valid_in;
   iqmp_rsp_type       out_data_ff;
   iqmp_rsp_type       out_data_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   iqmp_rsp_type       skid_data_ff;
   iqmp_rsp_type       skid_data_in;
   iqmp_rsp_type       result;
   logic               round_up;
   logic [ROOT_W:0]    amp_sum;
   logic [ANGLE_W-1:0] z_round;
   logic               new_beat;

   // Round the root to nearest, saturate; round the angle to its upper half
   always_comb begin
      round_up = last_data.rem > REM_W'(last_data.root);
      amp_sum  = {1'b0, last_data.root} + (ROOT_W + 1)'(round_up);
      z_round  = last_data.z + ANGLE_HALF;
      if (amp_sum > (ROOT_W + 1)'({AMP_W{1'b1}})) begin
         result.amplitude = {AMP_W{1'b1}};
      end else begin
         result.amplitude = AMP_W'(amp_sum);
      end
      result.phase_angle   = last_data.zero ? '0 : z_round[ANGLE_W-1 -: PHASE_W];
      result.pulse_end_out = last_data.pulse_end;
   end

   // Pipeline moves while the skid register is empty
   assign pipe_enable = !skid_valid_ff;
   assign new_beat    = pipe_enable && last_valid;

   // Refill the output from skid first, park a new beat in skid when stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_beat;
            out_data_in  = result;
         end
      end else if (new_beat) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   // Skid holds a beat only behind an occupied output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without output beat");

   // A beat leaving the chain against a stalled output lands in skid
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && pipe_enable && last_valid) |=> skid_valid_ff)
      else $error("result beat lost on stall");

   // A drained skid beat moves to the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid beat not drained");
`endif

endmodule
